@@ rtl/nmea_sentence_framer_core_macros.svh @@
// Assertion helpers for the sentence framer.
`ifndef NMEA_SENTENCE_FRAMER_CORE_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nsf_pkg.sv @@
`default_nettype none

package nsf_pkg;

    localparam int MAX_SENTENCE_BYTES_DEF = 128;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    localparam logic [31:0] TAG_GGA  = "GGA,";
    localparam logic [31:0] TAG_RMC  = "RMC,";
    localparam logic [31:0] TAG_GST  = "GST,";
    localparam logic [31:0] TAG_GSA  = "GSA,";
    localparam logic [31:0] TAG_VTG  = "VTG,";
    localparam logic [39:0] TAG_PSTM = "PSTM,";

    localparam logic [7:0] MIN_COMMAS_GGA = 8'd14;
    localparam logic [7:0] MIN_COMMAS_RMC = 8'd11;
    localparam logic [7:0] NUM_COMMAS_GST = 8'd8;
    localparam logic [7:0] MIN_COMMAS_GSA = 8'd17;
    localparam logic [7:0] MIN_COMMAS_VTG = 8'd8;

    localparam int HDR_DEPTH = 6;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_GGA     = 3'd1,
        KIND_RMC     = 3'd2,
        KIND_GST     = 3'd3,
        KIND_GSA     = 3'd4,
        KIND_VTG     = 3'd5,
        KIND_PSTM    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BODY   = 3'd1,
        PH_HEX_HI = 3'd2,
        PH_HEX_LO = 3'd3,
        PH_END1   = 3'd4,
        PH_END2   = 3'd5
    } t_phase;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } t_hex;

    typedef struct packed {
        logic       checksum_ok;
        t_kind      sentence_kind;
        logic [7:0] talker_first;
        logic [7:0] talker_second;
        logic [7:0] field_separators;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic [7:0] sentence_bytes;
    } t_result;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex res;
        res.bad   = 1'b0;
        res.value = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            res.value = 4'(c - CH_0);
        end else if (c >= CH_UA && c <= CH_UF) begin
            res.value = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF) begin
            res.value = 4'(c - CH_LA + 8'd10);
        end else begin
            res.bad = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nmea_sentence_framer_core.sv @@
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------
// rx       | in        | i_rx_valid / o_rx_ready   | i_rx_byte
// res      | out       | o_res_valid / i_res_ready | o_checksum_ok .. o_sentence_bytes
//
// One byte transaction per cycle, sustained while the result side keeps up.
// A result is presented the cycle after the sentence's last byte, or waits in the
// skid entry while an earlier result is still held in the output register.
// o_rx_ready falls only while that skid entry is occupied.
// i_rst_n is synchronous, active low: the framer returns to idle, both result
// entries are emptied.
`default_nettype none

`include "nmea_sentence_framer_core_macros.svh"

module nmea_sentence_framer_core #(
    parameter int MAX_SENTENCE_BYTES = nsf_pkg::MAX_SENTENCE_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rx_valid,
    output logic                  o_rx_ready,
    input  wire logic [7:0]       i_rx_byte,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output logic                  o_checksum_ok,
    output nsf_pkg::t_kind        o_sentence_kind,
    output logic [7:0]            o_talker_first,
    output logic [7:0]            o_talker_second,
    output logic [7:0]            o_field_separators,
    output logic [7:0]            o_received_sum,
    output logic [7:0]            o_computed_sum,
    output logic [7:0]            o_sentence_bytes
);
    import nsf_pkg::*;

    // Position at which the next byte would overrun the sentence buffer.
    localparam logic [7:0] MAX_POS = 8'(MAX_SENTENCE_BYTES);

    // Framing state
    t_phase     r_phase, n_phase;
    logic [7:0] r_xor;
    logic [7:0] r_commas;
    logic [7:0] r_byte_pos;
    logic [7:0] r_hex_val;
    logic       r_hex_err;
    logic [7:0] r_hdr [HDR_DEPTH];

    // Result buffer: output register plus one skid entry
    logic       r_out_valid;
    t_result    r_out;
    logic       r_skid_valid;
    t_result    r_skid;

    logic       rx_fire;
    logic       out_fire;
    logic       is_dollar;
    logic       phase_live;
    logic       overflow;
    logic       take;       // byte belongs to the open sentence
    logic       complete;   // byte closes the sentence
    t_hex       hex;
    logic [7:0] hdr_eff [HDR_DEPTH];
    logic       sum_ok;
    t_kind      kind;
    t_result    new_res;

    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign out_fire   = r_out_valid && i_res_ready;
    assign o_rx_ready = !r_skid_valid;
    assign is_dollar  = (i_rx_byte == CH_DOLLAR);
    assign overflow   = (r_byte_pos >= MAX_POS);
    assign hex        = hex_decode(i_rx_byte);

    // Phase control: next state
    always_comb begin
        n_phase = r_phase;
        if (rx_fire) begin
            if (is_dollar) begin
                n_phase = PH_BODY;
            end else if (!phase_live || overflow) begin
                n_phase = PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_BODY:   n_phase = (i_rx_byte == CH_STAR) ? PH_HEX_HI : PH_BODY;
                    PH_HEX_HI: n_phase = PH_HEX_LO;
                    PH_HEX_LO: n_phase = PH_END1;
                    PH_END1:   n_phase = PH_END2;
                    default:   n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Phase control: decoded outputs
    always_comb begin
        unique case (r_phase)
            PH_BODY, PH_HEX_HI, PH_HEX_LO, PH_END1, PH_END2: phase_live = 1'b1;
            default:                                         phase_live = 1'b0;
        endcase
        take     = rx_fire && !is_dollar && phase_live && !overflow;
        complete = take && (r_phase == PH_END2);
    end

    // Header bytes as seen after this byte's write; the closing byte may land in them.
    always_comb begin
        for (int k = 0; k < HDR_DEPTH; k++) begin
            hdr_eff[k] = (take && r_byte_pos == 8'(k + 1)) ? i_rx_byte : r_hdr[k];
        end
    end

    // Verdict and kind
    always_comb begin
        sum_ok = !r_hex_err && (r_hex_val == r_xor);
        kind   = KIND_UNKNOWN;
        if ({hdr_eff[2], hdr_eff[3], hdr_eff[4], hdr_eff[5]} == TAG_GGA
                && r_commas >= MIN_COMMAS_GGA) begin
            kind = KIND_GGA;
        end else if ({hdr_eff[2], hdr_eff[3], hdr_eff[4], hdr_eff[5]} == TAG_RMC
                && r_commas >= MIN_COMMAS_RMC) begin
            kind = KIND_RMC;
        end else if ({hdr_eff[2], hdr_eff[3], hdr_eff[4], hdr_eff[5]} == TAG_GST
                && r_commas == NUM_COMMAS_GST) begin
            kind = KIND_GST;
        end else if ({hdr_eff[2], hdr_eff[3], hdr_eff[4], hdr_eff[5]} == TAG_GSA
                && r_commas >= MIN_COMMAS_GSA) begin
            kind = KIND_GSA;
        end else if ({hdr_eff[2], hdr_eff[3], hdr_eff[4], hdr_eff[5]} == TAG_VTG
                && r_commas >= MIN_COMMAS_VTG) begin
            kind = KIND_VTG;
        end else if ({hdr_eff[0], hdr_eff[1], hdr_eff[2], hdr_eff[3], hdr_eff[4]}
                == TAG_PSTM) begin
            kind = KIND_PSTM;
        end

        new_res.checksum_ok      = sum_ok;
        new_res.sentence_kind    = sum_ok ? kind : KIND_UNKNOWN;
        new_res.talker_first     = hdr_eff[0];
        new_res.talker_second    = hdr_eff[1];
        new_res.field_separators = r_commas;
        new_res.received_sum     = r_hex_val;
        new_res.computed_sum     = r_xor;
        new_res.sentence_bytes   = r_byte_pos + 8'd1;
    end

    // Framing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_xor      <= 8'd0;
            r_commas   <= 8'd0;
            r_byte_pos <= 8'd0;
            r_hex_val  <= 8'd0;
            r_hex_err  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (rx_fire && is_dollar) begin
                // '$' restarts from any phase
                r_xor      <= 8'd0;
                r_commas   <= 8'd0;
                r_byte_pos <= 8'd1;
                r_hex_val  <= 8'd0;
                r_hex_err  <= 1'b0;
            end else if (take) begin
                r_byte_pos <= r_byte_pos + 8'd1;
                case (r_phase)
                    PH_BODY: begin
                        if (i_rx_byte != CH_STAR) begin
                            r_xor <= r_xor ^ i_rx_byte;
                            if (i_rx_byte == CH_COMMA) begin
                                r_commas <= r_commas + 8'd1;
                            end
                        end
                    end
                    PH_HEX_HI: begin
                        r_hex_val <= {hex.value, 4'd0};
                        if (hex.bad) begin
                            r_hex_err <= 1'b1;
                        end
                    end
                    PH_HEX_LO: begin
                        r_hex_val <= {r_hex_val[7:4], hex.value};
                        if (hex.bad) begin
                            r_hex_err <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Header capture, sentence bytes 1..6
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HDR_DEPTH; k++) begin
            r_hdr[k] <= hdr_eff[k];
        end
    end

    // Result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // skid full: no new transaction can arrive
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (complete) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result buffer payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (complete) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= new_res;
            end else begin
                r_out <= new_res;
            end
        end
    end

    assign o_res_valid        = r_out_valid;
    assign o_checksum_ok      = r_out.checksum_ok;
    assign o_sentence_kind    = r_out.sentence_kind;
    assign o_talker_first     = r_out.talker_first;
    assign o_talker_second    = r_out.talker_second;
    assign o_field_separators = r_out.field_separators;
    assign o_received_sum     = r_out.received_sum;
    assign o_computed_sum     = r_out.computed_sum;
    assign o_sentence_bytes   = r_out.sentence_bytes;

    // Checks
    `NSF_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry without output entry")
    `NSF_ASSERT_NEXT(a_close_gives_result, i_clk, i_rst_n, complete, r_out_valid,
        "closing byte left no result")
    `NSF_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_res_ready,
        !r_skid_valid, "skid entry not drained after output transaction")
    `NSF_ASSERT_NOW(a_pos_bounded, i_clk, i_rst_n, r_phase != PH_IDLE,
        r_byte_pos != 8'd0 && r_byte_pos <= MAX_POS, "byte position outside sentence buffer")
    `NSF_ASSERT_NOW(a_kind_needs_sum, i_clk, i_rst_n,
        r_out_valid && r_out.sentence_kind != KIND_UNKNOWN,
        r_out.checksum_ok && r_out.received_sum == r_out.computed_sum,
        "kind reported on failed checksum")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import nsf_pkg::*;

    localparam int MAX_BYTES     = MAX_SENTENCE_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 100;   // bytes of random traffic
    localparam int LONG_HOLD     = 300;   // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 10;    // idle wait before the final verdict
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_NL = 8'h0A;

    // How the checksum part of a generated sentence is formed.
    typedef enum int {
        SUM_GOOD,
        SUM_WRONG,
        SUM_BAD_DIGIT,
        SUM_STAR_DIGIT,
        SUM_STAR_EOL
    } t_sum_mode;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_ready;
    logic       checksum_ok;
    t_kind      sentence_kind;
    logic [7:0] talker_first;
    logic [7:0] talker_second;
    logic [7:0] field_separators;
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    logic [7:0] sentence_bytes;

    nmea_sentence_framer_core #(
        .MAX_SENTENCE_BYTES(MAX_BYTES)
    ) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_rx_valid        (rx_valid),
        .o_rx_ready        (rx_ready),
        .i_rx_byte         (rx_byte),
        .o_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .o_checksum_ok     (checksum_ok),
        .o_sentence_kind   (sentence_kind),
        .o_talker_first    (talker_first),
        .o_talker_second   (talker_second),
        .o_field_separators(field_separators),
        .o_received_sum    (received_sum),
        .o_computed_sum    (computed_sum),
        .o_sentence_bytes  (sentence_bytes)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Framer prediction: our own copy of the sentence state.
    // ------------------------------------------------------------------
    t_phase     fr_phase;
    logic [7:0] fr_xor;
    logic [7:0] fr_commas;
    logic [7:0] fr_pos;
    logic [7:0] fr_hdr [HDR_DEPTH];
    logic [7:0] fr_hex;
    logic       fr_hex_bad;

    t_result    pending_results [$];
    t_result    want_result;
    int         mismatches = 0;
    int         bytes_offered = 0;

    // Sender and receiver pacing knobs.
    bit         no_gaps = 1'b0;
    bit         res_hold = 1'b0;
    event       hold_start;

    logic [7:0] sentence_body [$];

    task automatic framer_clear();
        fr_phase   = PH_IDLE;
        fr_xor     = 8'd0;
        fr_commas  = 8'd0;
        fr_pos     = 8'd0;
        fr_hex     = 8'd0;
        fr_hex_bad = 1'b0;
        for (int i = 0; i < HDR_DEPTH; i++) fr_hdr[i] = 8'd0;
    endtask

    // {bad, value} of one checksum character; either case of a-f is a digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return {1'b0, 4'(c - CH_0)};
        if (c >= CH_UA && c <= CH_UF) return {1'b0, 4'(c - CH_UA + 8'd10)};
        if (c >= CH_LA && c <= CH_LF) return {1'b0, 4'(c - CH_LA + 8'd10)};
        return 5'b1_0000;
    endfunction

    // Kind from sentence bytes 1..6 plus the comma rule of that kind.
    function automatic t_kind kind_from_header();
        logic [31:0] tag3;
        logic [39:0] tag5;
        tag3 = {fr_hdr[2], fr_hdr[3], fr_hdr[4], fr_hdr[5]};
        tag5 = {fr_hdr[0], fr_hdr[1], fr_hdr[2], fr_hdr[3], fr_hdr[4]};
        if (tag3 == TAG_GGA && fr_commas >= MIN_COMMAS_GGA) return KIND_GGA;
        if (tag3 == TAG_RMC && fr_commas >= MIN_COMMAS_RMC) return KIND_RMC;
        if (tag3 == TAG_GST && fr_commas == NUM_COMMAS_GST) return KIND_GST;
        if (tag3 == TAG_GSA && fr_commas >= MIN_COMMAS_GSA) return KIND_GSA;
        if (tag3 == TAG_VTG && fr_commas >= MIN_COMMAS_VTG) return KIND_VTG;
        if (tag5 == TAG_PSTM) return KIND_PSTM;
        return KIND_UNKNOWN;
    endfunction

    // Advance the framer by one accepted byte; queue a result on the closing byte.
    task automatic frame_byte(input logic [7:0] b);
        logic [4:0] nib;
        t_result    r;
        logic       ok;
        nib = nibble_of(b);
        if (b == CH_DOLLAR) begin
            // a dollar restarts from any phase
            fr_phase   = PH_BODY;
            fr_xor     = 8'd0;
            fr_commas  = 8'd0;
            fr_pos     = 8'd1;
            fr_hex     = 8'd0;
            fr_hex_bad = 1'b0;
        end else if (fr_phase == PH_IDLE) begin
            // noise between sentences
        end else if (int'(fr_pos) + 1 > MAX_BYTES) begin
            fr_phase = PH_IDLE;  // overlong, dropped without a result
        end else begin
            if (fr_pos >= 8'd1 && fr_pos <= 8'd6) fr_hdr[fr_pos - 8'd1] = b;
            fr_pos = fr_pos + 8'd1;
            case (fr_phase)
                PH_BODY: begin
                    if (b == CH_STAR) begin
                        fr_phase = PH_HEX_HI;
                    end else begin
                        fr_xor = fr_xor ^ b;
                        if (b == CH_COMMA) fr_commas = fr_commas + 8'd1;
                    end
                end
                PH_HEX_HI: begin
                    fr_hex     = {nib[3:0], 4'h0};
                    fr_hex_bad = fr_hex_bad | nib[4];
                    fr_phase   = PH_HEX_LO;
                end
                PH_HEX_LO: begin
                    fr_hex     = fr_hex | {4'h0, nib[3:0]};
                    fr_hex_bad = fr_hex_bad | nib[4];
                    fr_phase   = PH_END1;
                end
                PH_END1: begin
                    fr_phase = PH_END2;
                end
                default: begin
                    ok = !fr_hex_bad && (fr_hex == fr_xor);
                    r.checksum_ok      = ok;
                    r.sentence_kind    = ok ? kind_from_header() : KIND_UNKNOWN;
                    r.talker_first     = fr_hdr[0];
                    r.talker_second    = fr_hdr[1];
                    r.field_separators = fr_commas;
                    r.received_sum     = fr_hex;
                    r.computed_sum     = fr_xor;
                    r.sentence_bytes   = fr_pos;
                    pending_results.push_back(r);
                    fr_phase = PH_IDLE;
                end
            endcase
        end
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected 0x%02h, got 0x%02h", name, want, got);
        end
    endtask

    // Result check comes before prediction so a result is always matched
    // against expectations from earlier byte transactions.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid && res_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: result transaction with no sentence pending");
                end else begin
                    want_result = pending_results.pop_front();
                    cmp_field("checksum_ok", 8'(want_result.checksum_ok), 8'(checksum_ok));
                    cmp_field("sentence_kind", 8'(want_result.sentence_kind),
                              8'(sentence_kind));
                    cmp_field("talker_first", want_result.talker_first, talker_first);
                    cmp_field("talker_second", want_result.talker_second, talker_second);
                    cmp_field("field_separators", want_result.field_separators,
                              field_separators);
                    cmp_field("received_sum", want_result.received_sum, received_sum);
                    cmp_field("computed_sum", want_result.computed_sum, computed_sum);
                    cmp_field("sentence_bytes", want_result.sentence_bytes, sentence_bytes);
                end
            end
            if (rx_valid && rx_ready) frame_byte(rx_byte);
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall per result, plus the long hold-off.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        res_ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0 || res_hold) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (res_hold) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    // Long receiver hold-off, timed here so the sender keeps offering bytes.
    initial begin
        forever begin
            @(hold_start);
            res_hold = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            res_hold = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Byte sender and sentence builders.
    // ------------------------------------------------------------------
    // Offer one byte; returns in the time step of its transaction.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        bytes_offered++;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
    endtask

    // Sender pause: drop valid and wait for every pending result.
    task automatic wait_results_drained();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) sentence_body.push_back(8'(s[i]));
    endtask

    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) begin
            c = ($urandom_range(0, 10) == 10) ? 8'h2E : 8'(CH_0 + $urandom_range(0, 9));
        end else begin
            c = 8'($urandom_range(8'h20, 8'hFF));
            if (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA) c = 8'h58;
        end
        return c;
    endfunction

    // n commas with random fields of up to max_len characters around them.
    task automatic put_fields(input int n, input int max_len);
        for (int i = 0; i <= n; i++) begin
            repeat ($urandom_range(0, max_len)) sentence_body.push_back(field_char());
            if (i < n) sentence_body.push_back(CH_COMMA);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return CH_0 + 8'(n);
        return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 7))
            0: return 8'h47;  // G
            1: return 8'h67;  // g
            2: return 8'h2F;  // just below 0
            3: return 8'h3A;  // just above 9
            4: return 8'h40;  // just below A
            5: return 8'h60;  // just below a
            6: return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    // '$', the queued body, then tail_len of: '*', two hex digits, CR, LF.
    task automatic send_sentence(input t_sum_mode mode, input bit lower_hex, input int tail_len);
        logic [7:0] sum;
        logic [7:0] tail [5];
        sum = 8'd0;
        foreach (sentence_body[j]) sum = sum ^ sentence_body[j];
        if (mode == SUM_WRONG) sum = sum ^ 8'($urandom_range(1, 255));
        tail[0] = CH_STAR;
        tail[1] = hex_char(sum[7:4], lower_hex);
        tail[2] = hex_char(sum[3:0], lower_hex);
        tail[3] = CH_CR;
        tail[4] = CH_NL;
        case (mode)
            SUM_BAD_DIGIT:  tail[1 + $urandom_range(0, 1)] = non_hex_char();
            SUM_STAR_DIGIT: tail[1 + $urandom_range(0, 1)] = CH_STAR;
            SUM_STAR_EOL:   tail[3 + $urandom_range(0, 1)] = CH_STAR;
            default: ;
        endcase
        send_byte(CH_DOLLAR);
        foreach (sentence_body[j]) send_byte(sentence_body[j]);
        for (int i = 0; i < tail_len; i++) send_byte(tail[i]);
        sentence_body.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Each kind at its comma threshold, and GGA, GST and VTG just off it.
    task automatic test_sentence_kinds();
        put_text("GPGGA,"); put_fields(13, 1); send_sentence(SUM_GOOD, 1'b0, 5);
        put_text("GPGGA,"); put_fields(12, 1); send_sentence(SUM_GOOD, 1'b0, 5);
        put_text("GNRMC,"); put_fields(10, 1); send_sentence(SUM_GOOD, 1'b1, 5);
        put_text("GPGST,"); put_fields(7, 1);  send_sentence(SUM_GOOD, 1'b0, 5);
        put_text("GPGST,"); put_fields(8, 1);  send_sentence(SUM_GOOD, 1'b1, 5);
        put_text("GPGSA,"); put_fields(16, 0); send_sentence(SUM_GOOD, 1'b0, 5);
        put_text("GPVTG,"); put_fields(7, 1);  send_sentence(SUM_GOOD, 1'b1, 5);
        put_text("GPVTG,"); put_fields(6, 1);  send_sentence(SUM_GOOD, 1'b0, 5);
        put_text("PSTM,");  put_fields(1, 2);  send_sentence(SUM_GOOD, 1'b0, 5);
        // valid kind but wrong checksum reports unknown
        put_text("GPRMC,"); put_fields(11, 1); send_sentence(SUM_WRONG, 1'b0, 5);
        wait_results_drained();
    endtask

    task automatic test_framing_corners();
        // idle noise is ignored
        send_byte(8'h00); send_byte(8'hFF); send_byte(CH_STAR); send_byte(CH_COMMA);
        // shortest sentence: empty body
        send_sentence(SUM_GOOD, 1'b0, 5);
        // a dollar in each phase abandons the open sentence
        for (int k = 0; k < 5; k++) begin
            put_text("GPHDT,1");
            send_sentence(SUM_GOOD, 1'b0, k);
        end
        put_text("GPHDT,1"); send_sentence(SUM_GOOD, 1'b1, 5);
        // a star where digits or line end are expected is just another byte
        put_text("GPZDA,2"); send_sentence(SUM_STAR_DIGIT, 1'b0, 5);
        put_text("GPZDA,3"); send_sentence(SUM_STAR_EOL, 1'b0, 5);
        put_text("GPZDA,4"); send_sentence(SUM_BAD_DIGIT, 1'b1, 5);
        // back-to-back dollars
        send_byte(CH_DOLLAR);
        put_text("GPTXT,x"); send_sentence(SUM_GOOD, 1'b1, 5);
        wait_results_drained();
    endtask

    task automatic test_overlong();
        // exactly the buffer size is still framed
        put_text("GP");
        repeat (MAX_BYTES - 8) sentence_body.push_back(CH_COMMA);
        send_sentence(SUM_GOOD, 1'b0, 5);
        // one byte longer is dropped on its final byte
        put_text("GP");
        repeat (MAX_BYTES - 7) sentence_body.push_back(CH_COMMA);
        send_sentence(SUM_GOOD, 1'b0, 5);
        // the overflowing byte is a dollar: it opens a fresh sentence
        put_fields(MAX_BYTES - 1 - 60, 0);
        repeat (MAX_BYTES - 1 - sentence_body.size()) sentence_body.push_back(8'h41);
        send_sentence(SUM_GOOD, 1'b0, 0);
        put_text("GPGLL,5"); send_sentence(SUM_GOOD, 1'b0, 5);
        wait_results_drained();
    endtask

    // Receiver holds off while short sentences stream in back to back,
    // so both result entries fill and the byte channel stalls.
    task automatic test_backpressure();
        no_gaps = 1'b1;
        -> hold_start;
        repeat (6) begin
            put_text("GPZDA,"); put_fields(1, 1);
            send_sentence(SUM_GOOD, 1'(($urandom_range(0, 1))), 5);
        end
        no_gaps = 1'b0;
        wait_results_drained();
    endtask

    task automatic random_sentence();
        int        pick;
        int        n;
        int        roll;
        t_sum_mode mode;
        pick = $urandom_range(0, 7);
        roll = $urandom_range(0, 2);
        if (pick < 5 || pick == 6) begin
            if (roll == 0)      put_text("GP");
            else if (roll == 1) put_text("GN");
            else begin
                sentence_body.push_back(8'($urandom_range(8'h41, 8'h5A)));
                sentence_body.push_back(8'($urandom_range(8'h41, 8'h5A)));
            end
        end
        case (pick)
            0: begin put_text("GGA,"); n = $urandom_range(12, 16); end
            1: begin put_text("RMC,"); n = $urandom_range(9, 13);  end
            2: begin put_text("GST,"); n = $urandom_range(6, 10);  end
            3: begin put_text("GSA,"); n = $urandom_range(15, 19); end
            4: begin put_text("VTG,"); n = $urandom_range(6, 10);  end
            5: begin put_text("PSTM,"); n = $urandom_range(1, 5);  end
            6: begin
                repeat (3) sentence_body.push_back(8'($urandom_range(8'h41, 8'h5A)));
                sentence_body.push_back(CH_COMMA);
                n = $urandom_range(1, 5);
            end
            default: n = 0;
        endcase
        if (pick == 7) begin
            // tiny body, down to the six-byte sentence
            repeat ($urandom_range(0, 3)) sentence_body.push_back(field_char());
        end else begin
            put_fields(n - 1, 2);
        end
        roll = $urandom_range(0, 19);
        if (roll < 16)      mode = SUM_GOOD;
        else if (roll == 16) mode = SUM_WRONG;
        else if (roll == 17) mode = SUM_BAD_DIGIT;
        else if (roll == 18) mode = SUM_STAR_DIGIT;
        else                 mode = SUM_STAR_EOL;
        // one in ten is cut short before its line end
        send_sentence(mode, 1'(($urandom_range(0, 1))),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 5);
    endtask

    task automatic test_random_stream();
        int first_byte;
        first_byte = bytes_offered;
        while (bytes_offered - first_byte < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) no_gaps = ~no_gaps;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                random_sentence();
            end
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n    <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte  <= 8'd0;
        framer_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_sentence_kinds();
        test_framing_corners();
        test_overlong();
        test_backpressure();
        test_random_stream();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TB_ERROR");
        $finish;
    end

endmodule
